>>> sv/mvn_pkg.sv
package mvn_pkg;

    localparam int IDX_W   = 12;
    localparam int POS_W   = 16;
    localparam int EDGE_W  = 17;
    localparam int PROD_W  = 34;
    localparam int CROSS_W = 35;
    localparam int NRM_W   = 16;

    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_TRI    = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]              kind;
        logic [IDX_W-1:0]        vertex_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [IDX_W-1:0]        corner_a;
        logic [IDX_W-1:0]        corner_b;
        logic [IDX_W-1:0]        corner_c;
    } in_item_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic                    has_normal;
    } out_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] z;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] x;
    } pos_t;

endpackage

>>> sv/mvn_norm.sv
module mvn_norm
    import mvn_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic signed [CROSS_W-1:0] vx,
    input  logic signed [CROSS_W-1:0] vy,
    input  logic signed [CROSS_W-1:0] vz,
    output logic                      done,
    output out_item_t                 res
);

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SHIFT = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_SQRT  = 3'd3;
    localparam logic [2:0] N_DLOAD = 3'd4;
    localparam logic [2:0] N_DIV   = 3'd5;
    localparam logic [2:0] N_FIN   = 3'd6;

    localparam logic [CROSS_W-1:0] HI_LIM = CROSS_W'(64'd1 << 30);
    localparam logic [CROSS_W-1:0] LO_LIM = CROSS_W'(64'd1 << 29);

    logic [2:0]               state_reg;
    logic [CROSS_W-1:0]       m_reg [3];
    logic [2:0]               neg_reg;
    logic [4:0]               step_reg;
    logic [1:0]               idx_reg;
    logic [59:0]              prod_reg;
    logic [63:0]              ss_reg;
    logic [63:0]              v_reg;
    logic [63:0]              root_reg;
    logic [63:0]              bit_reg;
    logic [45:0]              rem_reg;
    logic [45:0]              dv_reg;
    logic [14:0]              q_reg;
    logic signed [NRM_W-1:0]  n_reg [3];
    logic                     done_reg;
    out_item_t                res_reg;

    logic [CROSS_W-1:0] mag_x, mag_y, mag_z, mx;
    logic [CROSS_W-1:0] m_sel;
    logic [29:0]        ms;
    logic [63:0]        trial;
    logic               qbit;
    logic [14:0]        qn;

    function automatic logic [CROSS_W-1:0] mag(input logic signed [CROSS_W-1:0] v);
        mag = v[CROSS_W-1] ? CROSS_W'(-v) : CROSS_W'(v);
    endfunction

    always_comb
    begin
        mag_x = mag(vx);
        mag_y = mag(vy);
        mag_z = mag(vz);
        mx = m_reg[0];
        if (m_reg[1] > mx)
        begin
            mx = m_reg[1];
        end
        if (m_reg[2] > mx)
        begin
            mx = m_reg[2];
        end
        m_sel = m_reg[idx_reg];
        ms    = m_sel[29:0];
        trial = root_reg + bit_reg;
        qbit  = (rem_reg >= dv_reg);
        qn    = {q_reg[13:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                N_IDLE:
                begin
                    if (go)
                    begin
                        m_reg[0] <= mag_x;
                        m_reg[1] <= mag_y;
                        m_reg[2] <= mag_z;
                        neg_reg  <= {vz[CROSS_W-1], vy[CROSS_W-1], vx[CROSS_W-1]};
                        if (mag_x == '0 && mag_y == '0 && mag_z == '0)
                        begin
                            res_reg  <= '0;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= N_SHIFT;
                        end
                    end
                end
                N_SHIFT:
                begin
                    if (mx >= HI_LIM)
                    begin
                        m_reg[0] <= m_reg[0] >> 1;
                        m_reg[1] <= m_reg[1] >> 1;
                        m_reg[2] <= m_reg[2] >> 1;
                    end
                    else if (mx < LO_LIM)
                    begin
                        m_reg[0] <= m_reg[0] << 1;
                        m_reg[1] <= m_reg[1] << 1;
                        m_reg[2] <= m_reg[2] << 1;
                    end
                    else
                    begin
                        step_reg  <= '0;
                        idx_reg   <= '0;
                        ss_reg    <= '0;
                        state_reg <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    if (step_reg == 5'd3)
                    begin
                        v_reg     <= ss_reg + 64'(prod_reg);
                        root_reg  <= '0;
                        bit_reg   <= 64'd1 << 62;
                        step_reg  <= '0;
                        state_reg <= N_SQRT;
                    end
                    else
                    begin
                        if (step_reg != 5'd0)
                        begin
                            ss_reg <= ss_reg + 64'(prod_reg);
                        end
                        prod_reg <= 60'(ms) * 60'(ms);
                        if (idx_reg != 2'd2)
                        begin
                            idx_reg <= idx_reg + 2'd1;
                        end
                        step_reg <= step_reg + 5'd1;
                    end
                end
                N_SQRT:
                begin
                    if (v_reg >= trial)
                    begin
                        v_reg    <= v_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg  <= bit_reg >> 2;
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd31)
                    begin
                        idx_reg   <= '0;
                        state_reg <= N_DLOAD;
                    end
                end
                N_DLOAD:
                begin
                    rem_reg   <= {ms, 14'd0} + 46'(root_reg[31:1]);
                    dv_reg    <= {root_reg[31:0], 14'd0};
                    q_reg     <= '0;
                    step_reg  <= '0;
                    state_reg <= N_DIV;
                end
                N_DIV:
                begin
                    if (qbit)
                    begin
                        rem_reg <= rem_reg - dv_reg;
                    end
                    q_reg    <= qn;
                    dv_reg   <= dv_reg >> 1;
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd14)
                    begin
                        n_reg[idx_reg] <= neg_reg[idx_reg] ? -NRM_W'(qn) : NRM_W'(qn);
                        if (idx_reg == 2'd2)
                        begin
                            state_reg <= N_FIN;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= N_DLOAD;
                        end
                    end
                end
                N_FIN:
                begin
                    res_reg.normal_x   <= n_reg[0];
                    res_reg.normal_y   <= n_reg[1];
                    res_reg.normal_z   <= n_reg[2];
                    res_reg.has_normal <= 1'b1;
                    done_reg           <= 1'b1;
                    state_reg          <= N_IDLE;
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

>>> sv/mesh_vertex_normals_top.sv
// Smooth vertex normals. Hold start high with an item; it is taken on a clock edge where busy
// is low, and busy stays high until the item is finished. A vertex write raises busy and an
// unused kind not at all. A triangle goes through the position reads, the serial cross product,
// the shared normalizer and three accumulator read-modify-writes through the sum memory, which
// has one read port and one write port; when the face has zero area nothing is accumulated. A
// query sends the sum to the same normalizer; a zero sum gives a zero result. The normalizer
// makes single-bit shifts to bring the largest component into range, then forms the squares,
// takes 32 root steps, divides each of the three components and finishes. A query result shows
// on result with result_valid high for one cycle and cannot be held off. After reset the sum
// memory is cleared one entry per cycle, all MAX_VERTICES entries, with busy high.
module mesh_vertex_normals_top
    import mvn_pkg::*;
#(
    parameter int MAX_VERTICES = 4096,
    parameter int SUM_WIDTH    = 24
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    output logic      result_valid,
    output out_item_t result
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int SW = SUM_WIDTH;

    localparam logic [3:0] T_CLEAR = 4'd0;
    localparam logic [3:0] T_IDLE  = 4'd1;
    localparam logic [3:0] T_WPOS  = 4'd2;
    localparam logic [3:0] T_RDA   = 4'd3;
    localparam logic [3:0] T_RDB   = 4'd4;
    localparam logic [3:0] T_RDC   = 4'd5;
    localparam logic [3:0] T_CAPC  = 4'd6;
    localparam logic [3:0] T_MUL   = 4'd7;
    localparam logic [3:0] T_NORM  = 4'd8;
    localparam logic [3:0] T_NWAIT = 4'd9;
    localparam logic [3:0] T_SRD   = 4'd10;
    localparam logic [3:0] T_SWR   = 4'd11;
    localparam logic [3:0] T_QRD   = 4'd12;
    localparam logic [3:0] T_QGO   = 4'd13;
    localparam logic [3:0] T_QWAIT = 4'd14;

    logic [3:0]                state_reg;
    logic [AW-1:0]             clr_reg;
    in_item_t                  item_reg;
    pos_t                      pa_reg, pb_reg;
    logic signed [EDGE_W-1:0]  e1_reg [3];
    logic signed [EDGE_W-1:0]  e2_reg [3];
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [CROSS_W-1:0] cr_reg [3];
    logic [2:0]                step_reg;
    logic [1:0]                k_reg;
    out_item_t                 fn_reg;
    logic                      result_valid_reg;
    out_item_t                 result_reg;

    pos_t                      pos_mem [MAX_VERTICES];
    logic [3*SW-1:0]           sum_mem [MAX_VERTICES];
    pos_t                      pos_q;
    logic [3*SW-1:0]           sum_q;

    logic [AW-1:0]             pos_raddr, sum_raddr, sum_waddr, corner_addr;
    logic                      sum_we;
    logic [3*SW-1:0]           sum_wdata;
    logic signed [EDGE_W-1:0]  op_a, op_b;
    logic [1:0]                cr_idx;
    logic [2:0]                step_m1;
    logic signed [SW-1:0]      sx, sy, sz;
    logic signed [CROSS_W-1:0] nv_x, nv_y, nv_z;
    logic                      nrm_go, nrm_done;
    out_item_t                 nrm_res;

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        in_range = (32'(idx) < MAX_VERTICES);
    endfunction

    function automatic logic [SW-1:0] sat_add(input logic signed [SW-1:0] s,
                                              input logic signed [NRM_W-1:0] a);
        logic signed [SW:0] r;
        r = (SW+1)'(s) + (SW+1)'(a);
        if (r[SW] != r[SW-1])
        begin
            sat_add = r[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
        else
        begin
            sat_add = r[SW-1:0];
        end
    endfunction

    always_comb
    begin
        case (k_reg)
            2'd0:    corner_addr = AW'(item_reg.corner_a);
            2'd1:    corner_addr = AW'(item_reg.corner_b);
            default: corner_addr = AW'(item_reg.corner_c);
        endcase
        case (state_reg)
            T_RDA:   pos_raddr = AW'(item_reg.corner_a);
            T_RDB:   pos_raddr = AW'(item_reg.corner_b);
            default: pos_raddr = AW'(item_reg.corner_c);
        endcase
        sum_raddr = (state_reg == T_QRD) ? AW'(item_reg.vertex_index) : corner_addr;
        sum_we    = (state_reg == T_CLEAR) || (state_reg == T_SWR);
        sum_waddr = (state_reg == T_CLEAR) ? clr_reg : corner_addr;
        sx = sum_q[SW-1:0];
        sy = sum_q[2*SW-1:SW];
        sz = sum_q[3*SW-1:2*SW];
        if (state_reg == T_CLEAR)
        begin
            sum_wdata = '0;
        end
        else
        begin
            sum_wdata = {sat_add(sz, fn_reg.normal_z), sat_add(sy, fn_reg.normal_y),
                         sat_add(sx, fn_reg.normal_x)};
        end
        case (step_reg)
            3'd0:    begin op_a = e1_reg[1]; op_b = e2_reg[2]; end
            3'd1:    begin op_a = e1_reg[2]; op_b = e2_reg[1]; end
            3'd2:    begin op_a = e1_reg[2]; op_b = e2_reg[0]; end
            3'd3:    begin op_a = e1_reg[0]; op_b = e2_reg[2]; end
            3'd4:    begin op_a = e1_reg[0]; op_b = e2_reg[1]; end
            default: begin op_a = e1_reg[1]; op_b = e2_reg[0]; end
        endcase
        step_m1 = step_reg - 3'd1;
        cr_idx  = step_m1[2:1];
        nrm_go  = (state_reg == T_NORM) || (state_reg == T_QGO);
        if (state_reg == T_QGO)
        begin
            nv_x = CROSS_W'(sx);
            nv_y = CROSS_W'(sy);
            nv_z = CROSS_W'(sz);
        end
        else
        begin
            nv_x = cr_reg[0];
            nv_y = cr_reg[1];
            nv_z = cr_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == T_WPOS)
        begin
            pos_mem[AW'(item_reg.vertex_index)] <= {item_reg.pos_z, item_reg.pos_y,
                                                    item_reg.pos_x};
        end
        pos_q <= pos_mem[pos_raddr];
        if (sum_we)
        begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        sum_q <= sum_mem[sum_raddr];
    end

    mvn_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (nrm_go),
        .vx    (nv_x),
        .vy    (nv_y),
        .vz    (nv_z),
        .done  (nrm_done),
        .res   (nrm_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= T_CLEAR;
            clr_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            case (state_reg)
                T_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(MAX_VERTICES - 1))
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                T_IDLE:
                begin
                    if (start)
                    begin
                        item_reg <= item;
                        case (item.kind)
                            KIND_VERTEX:
                            begin
                                if (in_range(item.vertex_index))
                                begin
                                    state_reg <= T_WPOS;
                                end
                            end
                            KIND_TRI:
                            begin
                                if (in_range(item.corner_a) && in_range(item.corner_b) &&
                                    in_range(item.corner_c))
                                begin
                                    state_reg <= T_RDA;
                                end
                            end
                            KIND_QUERY:
                            begin
                                if (in_range(item.vertex_index))
                                begin
                                    state_reg <= T_QRD;
                                end
                                else
                                begin
                                    result_reg       <= '0;
                                    result_valid_reg <= 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                T_WPOS:
                begin
                    state_reg <= T_IDLE;
                end
                T_RDA:
                begin
                    state_reg <= T_RDB;
                end
                T_RDB:
                begin
                    pa_reg    <= pos_q;
                    state_reg <= T_RDC;
                end
                T_RDC:
                begin
                    pb_reg    <= pos_q;
                    state_reg <= T_CAPC;
                end
                T_CAPC:
                begin
                    e1_reg[0] <= EDGE_W'(pb_reg.x) - EDGE_W'(pa_reg.x);
                    e1_reg[1] <= EDGE_W'(pb_reg.y) - EDGE_W'(pa_reg.y);
                    e1_reg[2] <= EDGE_W'(pb_reg.z) - EDGE_W'(pa_reg.z);
                    e2_reg[0] <= EDGE_W'(pos_q.x) - EDGE_W'(pa_reg.x);
                    e2_reg[1] <= EDGE_W'(pos_q.y) - EDGE_W'(pa_reg.y);
                    e2_reg[2] <= EDGE_W'(pos_q.z) - EDGE_W'(pa_reg.z);
                    step_reg  <= '0;
                    state_reg <= T_MUL;
                end
                T_MUL:
                begin
                    prod_reg <= op_a * op_b;
                    if (step_reg != 3'd0)
                    begin
                        if (!step_m1[0])
                        begin
                            cr_reg[cr_idx] <= CROSS_W'(prod_reg);
                        end
                        else
                        begin
                            cr_reg[cr_idx] <= cr_reg[cr_idx] - CROSS_W'(prod_reg);
                        end
                    end
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd6)
                    begin
                        state_reg <= T_NORM;
                    end
                end
                T_NORM:
                begin
                    state_reg <= T_NWAIT;
                end
                T_NWAIT:
                begin
                    if (nrm_done)
                    begin
                        fn_reg <= nrm_res;
                        k_reg  <= '0;
                        state_reg <= nrm_res.has_normal ? T_SRD : T_IDLE;
                    end
                end
                T_SRD:
                begin
                    state_reg <= T_SWR;
                end
                T_SWR:
                begin
                    k_reg <= k_reg + 2'd1;
                    state_reg <= (k_reg == 2'd2) ? T_IDLE : T_SRD;
                end
                T_QRD:
                begin
                    state_reg <= T_QGO;
                end
                T_QGO:
                begin
                    state_reg <= T_QWAIT;
                end
                T_QWAIT:
                begin
                    if (nrm_done)
                    begin
                        result_reg       <= nrm_res;
                        result_valid_reg <= 1'b1;
                        state_reg        <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != T_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_CLEAR) |-> busy)
        else $error("item taken during clear");

    a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
        nrm_done |-> (state_reg == T_NWAIT || state_reg == T_QWAIT))
        else $error("normalizer finished with nobody waiting");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == T_QWAIT || (state_reg == T_IDLE && start)))
        else $error("result beat without a query");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nrm_done && nrm_res.has_normal) |->
            (nrm_res.normal_x <= 16'sd16384 && nrm_res.normal_x >= -16'sd16384 &&
             nrm_res.normal_y <= 16'sd16384 && nrm_res.normal_y >= -16'sd16384 &&
             nrm_res.normal_z <= 16'sd16384 && nrm_res.normal_z >= -16'sd16384))
        else $error("normal component out of range");

endmodule
